@@ rtl/spp_pkg.sv @@
// shared types and constants of the slider packet parser
package spp_pkg;

    // parser phases
    typedef enum logic [1:0] {
        PH_WAIT_CMD = 2'd0,
        PH_BODY     = 2'd1,
        PH_MARKER   = 2'd2,
        PH_CHECK    = 2'd3
    } phase_t;

    localparam int DEF_SLIDER_COUNT = 8;

    localparam int          CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_CODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_CODE = 1'b1;

    localparam logic [7:0] POS_CODE_RESET   = 8'd0;
    localparam logic [7:0] TOUCH_CODE_RESET = 8'd1;

    localparam logic [7:0] END_MARKER    = 8'hFE;
    localparam logic [6:0] POS_LEN_ADD   = 7'd4;
    localparam logic [6:0] TOUCH_LEN_ADD = 7'd3;

    // byte positions inside a frame and frame lengths including the marker
    localparam logic [2:0] IDX_CMD       = 3'd1;
    localparam logic [2:0] IDX_SLIDER    = 3'd1;
    localparam logic [2:0] IDX_VALUE_LO  = 3'd2;
    localparam logic [2:0] IDX_VALUE_HI  = 3'd3;
    localparam logic [2:0] POS_BODY_END  = 3'd4;
    localparam logic [2:0] TOUCH_BODY_END = 3'd3;
    localparam logic [2:0] POS_FRAME_LEN  = 3'd5;
    localparam logic [2:0] TOUCH_FRAME_LEN = 3'd4;

    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_TOUCH    = 1'b1;

    // frame classification handed from the checker to the sequencer
    typedef struct packed {
        logic cmd_is_pos;
        logic cmd_is_touch;
        logic pos_accept;
        logic touch_accept;
    } check_t;

endpackage

@@ rtl/spp_frame_check.sv @@
// command matching, checksum and slider range check of a stored frame
module spp_frame_check import spp_pkg::*; #(
    parameter int SLIDER_COUNT = DEF_SLIDER_COUNT
) (
    input  logic [7:0] cmd_byte,
    input  logic [7:0] slider_byte,
    input  logic [7:0] value_lo,
    input  logic [7:0] value_hi,
    input  logic [7:0] check_byte,
    input  logic [2:0] byte_count,
    input  logic [7:0] pos_code,
    input  logic [7:0] touch_code,
    output check_t     check
);

    localparam logic [8:0] SLIDER_LIMIT = 9'(SLIDER_COUNT);

    logic [6:0] pos_sum;
    logic [6:0] touch_sum;
    logic       slider_ok;

    // sums only need the low seven bits
    assign pos_sum   = cmd_byte[6:0] + slider_byte[6:0] + value_lo[6:0] + value_hi[6:0]
                     + check_byte[6:0] + POS_LEN_ADD;
    assign touch_sum = cmd_byte[6:0] + slider_byte[6:0] + value_lo[6:0]
                     + check_byte[6:0] + TOUCH_LEN_ADD;
    assign slider_ok = {1'b0, slider_byte} < SLIDER_LIMIT;

    always_comb
    begin
        check.cmd_is_pos   = (cmd_byte == pos_code);
        check.cmd_is_touch = (cmd_byte == touch_code);
        check.pos_accept   = (byte_count == POS_FRAME_LEN) && check.cmd_is_pos
                           && (pos_sum == 7'd0) && slider_ok;
        check.touch_accept = (byte_count == TOUCH_FRAME_LEN) && check.cmd_is_touch
                           && !check.cmd_is_pos && (touch_sum == 7'd0) && slider_ok;
    end

endmodule

@@ rtl/slider_packet_parser.sv @@
// top level of the slider packet parser: phase sequencer and update register
//
// usage
//   rx channel: one received byte per word (rx_valid / rx_ready / rx_byte)
//   update channel: one word per accepted frame (update_valid / update_ready,
//     update_kind, slider_index, slider_value)
//   cfg channel: writes the position and touch command codes, always ready,
//     index 0 position code, index 1 touch code
// timing
//   one byte is taken every cycle while rx_ready is high; the phase registers
//   and the stored frame bytes update at the accepting edge
//   the update appears in the cycle after the check byte is accepted, set by
//   the single update register behind the checksum logic
// stall
//   while an update waits, bytes keep flowing; only a check byte is held
//   off (rx_ready low) until the waiting update is taken
// reset
//   parser returns to waiting for a command byte, no update pending,
//   command codes go to 0 (position) and 1 (touch)
module slider_packet_parser import spp_pkg::*; #(
    parameter int SLIDER_COUNT = DEF_SLIDER_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // received bytes
    input  logic                 rx_valid,
    output logic                 rx_ready,
    input  logic [7:0]           rx_byte,
    // slider updates
    output logic                 update_valid,
    input  logic                 update_ready,
    output logic                 update_kind,
    output logic [2:0]           slider_index,
    output logic [15:0]          slider_value,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    // command codes
    logic [7:0] pos_code_reg;
    logic [7:0] touch_code_reg;

    // parser state
    phase_t     phase_reg, phase_next;
    logic [2:0] count_reg, count_next;
    logic [2:0] count_inc;

    // stored frame bytes, the marker is never needed again
    logic [7:0] cmd_reg;
    logic [7:0] slider_reg;
    logic [7:0] value_lo_reg;
    logic [7:0] value_hi_reg;

    // update register
    logic        upd_valid_reg, upd_valid_next;
    logic        upd_kind_reg;
    logic [2:0]  upd_index_reg;
    logic [15:0] upd_value_reg;

    logic   rx_fire;
    logic   is_cmd;
    logic   store_cmd;
    logic   store_body;
    logic   emit;
    check_t check;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_code_reg   <= POS_CODE_RESET;
            touch_code_reg <= TOUCH_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_POS_CODE:   pos_code_reg   <= cfg_data;
                REG_TOUCH_CODE: touch_code_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // only a check byte can produce an update, so only it waits for room
    assign rx_ready  = !((phase_reg == PH_CHECK) && upd_valid_reg && !update_ready);
    assign rx_fire   = rx_valid && rx_ready;
    assign is_cmd    = (rx_byte == pos_code_reg) || (rx_byte == touch_code_reg);
    assign count_inc = count_reg + 3'd1;

    spp_frame_check #(
        .SLIDER_COUNT (SLIDER_COUNT)
    ) u_check (
        .cmd_byte    (cmd_reg),
        .slider_byte (slider_reg),
        .value_lo    (value_lo_reg),
        .value_hi    (value_hi_reg),
        .check_byte  (rx_byte),
        .byte_count  (count_reg),
        .pos_code    (pos_code_reg),
        .touch_code  (touch_code_reg),
        .check       (check)
    );

    // next phase and byte count
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (rx_fire)
        begin
            case (phase_reg)
                PH_WAIT_CMD:
                begin
                    if (is_cmd)
                    begin
                        phase_next = PH_BODY;
                        count_next = IDX_CMD;
                    end
                    else
                    begin
                        count_next = 3'd0;
                    end
                end
                PH_BODY:
                begin
                    // codes may have moved since the command byte came in
                    count_next = count_inc;
                    if (check.cmd_is_pos)
                    begin
                        if (count_inc >= POS_BODY_END)
                            phase_next = PH_MARKER;
                    end
                    else if (check.cmd_is_touch)
                    begin
                        if (count_inc >= TOUCH_BODY_END)
                            phase_next = PH_MARKER;
                    end
                    else
                    begin
                        phase_next = PH_WAIT_CMD;
                        count_next = 3'd0;
                    end
                end
                PH_MARKER:
                begin
                    if (rx_byte == END_MARKER)
                    begin
                        phase_next = PH_CHECK;
                        count_next = count_inc;
                    end
                    else
                    begin
                        phase_next = PH_WAIT_CMD;
                        count_next = 3'd0;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_WAIT_CMD;
                    count_next = 3'd0;
                end
                default:
                begin
                    phase_next = PH_WAIT_CMD;
                    count_next = 3'd0;
                end
            endcase
        end
    end

    // byte stores and update strobe
    always_comb
    begin
        store_cmd  = 1'b0;
        store_body = 1'b0;
        emit       = 1'b0;
        case (phase_reg)
            PH_WAIT_CMD: store_cmd  = rx_fire && is_cmd;
            PH_BODY:     store_body = rx_fire;
            PH_MARKER:   ;
            PH_CHECK:    emit = rx_fire && (check.pos_accept || check.touch_accept);
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_CMD;
            count_reg <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // frame byte storage, written at the current count
    always_ff @(posedge clk)
    begin
        if (store_cmd)
            cmd_reg <= rx_byte;
        if (store_body)
        begin
            case (count_reg)
                IDX_SLIDER:   slider_reg   <= rx_byte;
                IDX_VALUE_LO: value_lo_reg <= rx_byte;
                IDX_VALUE_HI: value_hi_reg <= rx_byte;
                default:      ;
            endcase
        end
    end

    // update register, loaded only when empty or being drained
    always_comb
    begin
        upd_valid_next = upd_valid_reg;
        if (emit)
            upd_valid_next = 1'b1;
        else if (update_ready)
            upd_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upd_valid_reg <= 1'b0;
        else
            upd_valid_reg <= upd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            upd_index_reg <= slider_reg[2:0];
            if (check.pos_accept)
            begin
                upd_kind_reg  <= KIND_POSITION;
                upd_value_reg <= {value_hi_reg, value_lo_reg};
            end
            else
            begin
                upd_kind_reg  <= KIND_TOUCH;
                upd_value_reg <= {8'd0, value_lo_reg};
            end
        end
    end

    assign update_valid = upd_valid_reg;
    assign update_kind  = upd_kind_reg;
    assign slider_index = upd_index_reg;
    assign slider_value = upd_value_reg;

    // a waiting update is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_valid_reg && !update_ready) |-> !emit)
        else $error("update overwritten while stalled");

    // after the check byte the parser is back to waiting
    a_check_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && phase_reg == PH_CHECK) |=> (phase_reg == PH_WAIT_CMD && count_reg == 3'd0))
        else $error("parser not idle after check byte");

    // body phase never runs past the value high byte
    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (count_reg >= IDX_CMD && count_reg < POS_BODY_END))
        else $error("body byte count out of range");

    // check phase holds a full touch or position frame
    a_check_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CHECK) |-> (count_reg == TOUCH_FRAME_LEN || count_reg == POS_FRAME_LEN))
        else $error("check phase with wrong frame length");

    // a new update only follows an accepted check byte
    a_update_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!upd_valid_reg ##1 upd_valid_reg) |-> $past(rx_fire && phase_reg == PH_CHECK))
        else $error("update without a check byte");

endmodule

@@ tb/tb_top.sv @@
// testbench for the slider packet parser: frame stimulus, update prediction and checks
`timescale 1ns / 100ps

module tb_top;
    import spp_pkg::*;

    localparam int SLIDERS       = DEF_SLIDER_COUNT;
    // idle cycles with no word moving on any channel before the run is called hung
    localparam int STALL_LIMIT   = 2000;
    // cycles left after the last expected update before a register write or the end
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BYTES   = 260;

    typedef logic [7:0] byte_q_t[$];

    // one update word as the block presents it
    typedef struct packed {
        logic        kind;
        logic [2:0]  idx;
        logic [15:0] value;
    } slider_update_t;

    // tracks the parser state byte by byte and holds the updates still due
    class update_scoreboard;
        logic [7:0]     pos_code;
        logic [7:0]     touch_code;
        phase_t         phase;
        logic [2:0]     nbytes;
        logic [7:0]     frame[5];
        slider_update_t due_updates[$];
        int             errors;

        function new();
            pos_code   = POS_CODE_RESET;
            touch_code = TOUCH_CODE_RESET;
            phase      = PH_WAIT_CMD;
            nbytes     = 3'd0;
            foreach (frame[i]) frame[i] = 8'h00;
            errors     = 0;
        endfunction

        function void set_code(logic [CFG_IDX_W-1:0] idx, logic [7:0] code);
            if (idx == REG_POS_CODE)
                pos_code = code;
            else
                touch_code = code;
        endfunction

        function int pending();
            return due_updates.size();
        endfunction

        function void go_idle();
            phase  = PH_WAIT_CMD;
            nbytes = 3'd0;
        endfunction

        // a full frame buffer drops the frame
        function void store(logic [7:0] b);
            if (nbytes < 3'd5) begin
                frame[nbytes] = b;
                nbytes = nbytes + 3'd1;
            end
            else
                go_idle();
        endfunction

        // advances the parser by one accepted rx byte
        function void frame_byte(logic [7:0] b);
            int             s;
            slider_update_t upd;
            case (phase)
                PH_WAIT_CMD:
                begin
                    if (b == pos_code || b == touch_code) begin
                        frame[0] = b;
                        nbytes   = 3'd1;
                        phase    = PH_BODY;
                    end
                    else
                        go_idle();
                end
                PH_BODY:
                begin
                    store(b);
                    if (phase == PH_BODY) begin
                        // kind is looked up again on every body byte
                        if (frame[0] == pos_code) begin
                            if (nbytes > 3'd3) phase = PH_MARKER;
                        end
                        else if (frame[0] == touch_code) begin
                            if (nbytes > 3'd2) phase = PH_MARKER;
                        end
                        else
                            go_idle();
                    end
                end
                PH_MARKER:
                begin
                    if (b == END_MARKER) begin
                        store(b);
                        if (phase == PH_MARKER) phase = PH_CHECK;
                    end
                    else
                        go_idle();
                end
                default:
                begin
                    // stored length decides the kind, command must still match its code
                    if (nbytes == 3'd5 && frame[0] == pos_code) begin
                        s = int'(frame[0]) + int'(frame[1]) + int'(frame[2]) + int'(frame[3])
                            + int'(b) + int'(POS_LEN_ADD);
                        if (s[6:0] == 7'd0 && int'(frame[1]) < SLIDERS) begin
                            upd.kind  = KIND_POSITION;
                            upd.idx   = frame[1][2:0];
                            upd.value = {frame[3], frame[2]};
                            due_updates.push_back(upd);
                        end
                    end
                    else if (nbytes == 3'd4 && frame[0] == touch_code
                             && frame[0] != pos_code) begin
                        s = int'(frame[0]) + int'(frame[1]) + int'(frame[2]) + int'(b)
                            + int'(TOUCH_LEN_ADD);
                        if (s[6:0] == 7'd0 && int'(frame[1]) < SLIDERS) begin
                            upd.kind  = KIND_TOUCH;
                            upd.idx   = frame[1][2:0];
                            upd.value = {8'h00, frame[2]};
                            due_updates.push_back(upd);
                        end
                    end
                    go_idle();
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_update(logic kind, logic [2:0] idx, logic [15:0] value);
            slider_update_t exp_upd;
            if (due_updates.size() == 0) begin
                report($sformatf("update kind %0d slider %0d value %04h with none due",
                                 kind, idx, value));
                return;
            end
            exp_upd = due_updates.pop_front();
            if (kind !== exp_upd.kind)
                report($sformatf("update_kind %0d, want %0d", kind, exp_upd.kind));
            if (idx !== exp_upd.idx)
                report($sformatf("slider_index %0d, want %0d", idx, exp_upd.idx));
            if (value !== exp_upd.value)
                report($sformatf("slider_value %04h, want %04h", value, exp_upd.value));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 rx_valid = 1'b0;
    logic                 rx_ready;
    logic [7:0]           rx_byte = 8'h00;
    logic                 update_valid;
    logic                 update_ready = 1'b0;
    logic                 update_kind;
    logic [2:0]           slider_index;
    logic [15:0]          slider_value;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_POS_CODE;
    logic [7:0]           cfg_data = 8'h00;

    // calm flags switch off the random gaps for a while on each side
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int idle_cycles = 0;

    update_scoreboard sb;

    slider_packet_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .update_valid (update_valid),
        .update_ready (update_ready),
        .update_kind  (update_kind),
        .slider_index (slider_index),
        .slider_value (slider_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // hang detection: any word on any channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((rx_valid && rx_ready) || (update_valid && update_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // update sink: random stalls drawn per word, checked at the accepting edge
    initial
    begin : update_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 24) == 0) rx_calm = ~rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                update_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            update_ready <= 1'b1;
            @(posedge clk);
            while (!update_valid) @(posedge clk);
            sb.check_update(update_kind, slider_index, slider_value);
            @(negedge clk);
        end
    end

    // entered and left at a falling edge; valid stays up for a back-to-back byte
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        sb.frame_byte(b);
        @(negedge clk);
    endtask

    task automatic send_seq(input byte_q_t q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // stop sending and let every due update come out, then let the pipe settle
    task automatic drain_updates();
        rx_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // both codes in one burst of two cfg words
    task automatic write_codes(input logic [7:0] pos, input logic [7:0] touch);
        cfg_valid <= 1'b1;
        cfg_index <= REG_POS_CODE;
        cfg_data  <= pos;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_code(REG_POS_CODE, pos);
        @(negedge clk);
        cfg_index <= REG_TOUCH_CODE;
        cfg_data  <= touch;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_code(REG_TOUCH_CODE, touch);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // cmd, slider, value (one or two bytes), marker, check byte with random top bit
    function automatic byte_q_t make_frame(bit is_touch, logic [7:0] cmd, logic [7:0] slider,
                                           logic [15:0] value, logic [7:0] marker,
                                           bit bad_sum);
        byte_q_t    q;
        int         sum;
        logic [6:0] chk;
        q.push_back(cmd);
        q.push_back(slider);
        q.push_back(value[7:0]);
        if (!is_touch) q.push_back(value[15:8]);
        sum = is_touch ? int'(TOUCH_LEN_ADD) : int'(POS_LEN_ADD);
        foreach (q[i]) sum += int'(q[i]);
        chk = 7'(-sum);
        if (bad_sum) chk = chk + 7'($urandom_range(1, 127));
        q.push_back(marker);
        q.push_back({1'($urandom_range(0, 1)), chk});
        return q;
    endfunction

    // mostly clean frames, plus bad sums, wrong markers, cut frames and loose bytes
    task automatic run_random_phase(input int quota);
        int          sent;
        int          pick;
        int          cut;
        bit          is_touch;
        logic [7:0]  slider;
        logic [7:0]  marker;
        logic [15:0] value;
        byte_q_t     q;
        sent = 0;
        while (sent < quota) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 92) begin
                is_touch = $urandom_range(0, 1);
                slider   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
                                                       : 8'($urandom_range(0, 7));
                case ($urandom_range(0, 7))
                    0:       value = 16'h0000;
                    1:       value = 16'hFFFF;
                    default: value = 16'($urandom);
                endcase
                marker = END_MARKER;
                // wrong end marker, frame ends at the marker
                if (pick >= 78 && pick < 86) begin
                    marker = 8'($urandom_range(0, 255));
                    if (marker == END_MARKER) marker = 8'h00;
                end
                q = make_frame(is_touch, is_touch ? sb.touch_code : sb.pos_code, slider,
                               value, marker, pick >= 70 && pick < 78);
                if (pick >= 78 && pick < 86)
                    void'(q.pop_back());
                else if (pick >= 86) begin
                    cut = $urandom_range(1, q.size() - 1);
                    while (q.size() > cut) void'(q.pop_back());
                end
                send_seq(q);
                sent += q.size();
            end
            else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            // now and then the sender holds off until every update is out
            if ($urandom_range(0, 59) == 0) drain_updates();
        end
    endtask

    initial
    begin : stimulus
        byte_q_t    q;
        logic [7:0] code_a;
        logic [7:0] code_b;
        sb = new();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at the reset codes, no gaps
        tx_calm = 1'b1;
        send_byte(8'h55);                                          // loose byte while idle
        send_seq(make_frame(1'b0, POS_CODE_RESET, 8'd7, 16'hFFFF, END_MARKER, 1'b0));
        send_seq(make_frame(1'b1, TOUCH_CODE_RESET, 8'd0, 16'h0000, END_MARKER, 1'b0));
        q = make_frame(1'b1, TOUCH_CODE_RESET, 8'd3, 16'h00A5, 8'h00, 1'b0);
        void'(q.pop_back());
        send_seq(q);                                               // wrong end marker

        // codes change mid-frame: a position start turns into a touch frame
        q = make_frame(1'b1, 8'h00, 8'd2, 16'h009C, END_MARKER, 1'b0);
        send_byte(q[0]);
        send_byte(q[1]);
        drain_updates();
        write_codes(8'h80, 8'h00);
        send_byte(q[2]);
        send_byte(q[3]);
        send_byte(q[4]);

        // random phases, each under its own pair of codes
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_updates();
            code_a = 8'($urandom_range(0, 255));
            code_b = 8'($urandom_range(0, 255));
            case (p)
                0:       write_codes(8'h00, 8'hFF);
                1:       write_codes(8'hFF, 8'h00);
                2:       write_codes(code_a, code_a);              // equal codes
                3:       write_codes(END_MARKER, 8'h7F);
                default: write_codes(code_a, code_b);
            endcase
            run_random_phase(PHASE_BYTES);
        end

        drain_updates();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d updates never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spp_pkg.sv
rtl/spp_frame_check.sv
rtl/slider_packet_parser.sv
tb/tb_top.sv
